>>> design/rtm_pkg.sv
// Package for the region time monitor: state encoding, result codes and
// the result record shared by the top level and its output buffer.
// No dependencies.
package rtm_pkg;

  // Action codes reported with each result transaction.
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  // Time stack status codes.
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

  // Reset value of the minimum recorded interval, in ticks.
  localparam logic [31:0] MIN_INTERVAL_RESET = 32'd1000000;

  // Widths of the counters that do not scale with the parameters.
  localparam int unsigned SkipBits  = 16;
  localparam int unsigned CountBits = 32;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_PARENT
  } rtm_state_e;

  // One result transaction.
  typedef struct packed {
    logic [1:0]           action;
    logic [CountBits-1:0] measured_count;
    logic [1:0]           stack_error;
  } rtm_result_t;

endpackage

>>> design/rtm_out_buf.sv
// Output stage of the region time monitor: an output register plus one
// holding register, so a finished result can wait while the core works on.
// Depends on rtm_pkg.
module rtm_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  rtm_pkg::rtm_result_t data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rtm_pkg::rtm_result_t data_o
);
  import rtm_pkg::*;

  logic        out_valid_q, out_valid_d;
  logic        hold_valid_q, hold_valid_d;
  rtm_result_t out_q, out_d;
  rtm_result_t hold_q, hold_d;
  logic        free;

  // The output register can take new data when empty or being drained.
  assign free = !out_valid_q || !out_stall_i;

  // Next value: the held result goes first, then a fresh one.
  always_comb begin
    out_valid_d  = out_valid_q;
    hold_valid_d = hold_valid_q;
    out_d        = out_q;
    hold_d       = hold_q;
    if (hold_valid_q && free) begin
      out_d        = hold_q;
      out_valid_d  = 1'b1;
      hold_valid_d = 1'b0;
    end else if (load_i) begin
      if (free) begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end else begin
        hold_d       = data_i;
        hold_valid_d = 1'b1;
      end
    end else if (free) begin
      out_valid_d = 1'b0;
    end
  end

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    hold_q <= hold_d;
  end

  assign full_o      = hold_valid_q;
  assign out_valid_o = out_valid_q;
  assign data_o      = out_q;

endmodule

>>> design/region_time_monitor.sv
// Region time monitor top level: time stack memory, region table memory and
// the read-modify-write sequencer. Depends on rtm_pkg and rtm_out_buf.
//
//   Channel   Handshake                    Payload
//   -------   --------------------------   ------------------------------------
//   in        in_valid_i / in_stall_o      req_type, nested, region_valid,
//                                          region_id, parent_valid, parent_id,
//                                          timestamp
//   out       out_valid_o / out_stall_i    action, measured_count, stack_error
//   cfg       cfg_wen_i                    cfg_wdata_i (min_interval)
//
// A transaction is taken in ST_IDLE, which issues the table and stack reads,
// and is evaluated and written back in ST_EVAL. An end event that updates a
// parent entry adds an ST_PARENT step, since the parent is a second access to
// the single-write-port region table. After reset a clearing pass marks all
// REGION_COUNT entries invalid; no input transaction is taken until it is done.
// One finished result can wait in the output stage while the next input
// transaction is taken.
module region_time_monitor #(
  parameter int unsigned REGION_COUNT = 1024,
  parameter int unsigned STACK_DEPTH  = 64,
  parameter int unsigned TIME_BITS    = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wen_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic        nested_i,
  input  logic        region_valid_i,
  input  logic [9:0]  region_id_i,
  input  logic        parent_valid_i,
  input  logic [9:0]  parent_id_i,
  input  logic [47:0] timestamp_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic [31:0] measured_count_o,
  output logic [1:0]  stack_error_o
);
  import rtm_pkg::*;

  localparam int unsigned RW = $clog2(REGION_COUNT);
  localparam int unsigned SW = $clog2(STACK_DEPTH);
  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned EW = 2 * TW + 1;
  localparam int unsigned CW = (TIME_BITS > 32) ? TIME_BITS : 32;

  // Sequencer and control state.
  rtm_state_e              state_q, state_d;
  logic [RW-1:0]           clr_q, clr_d;
  logic [LW-1:0]           level_q, level_d;
  logic                    measuring_q, measuring_d;
  logic [SkipBits-1:0]     skip_q, skip_d;
  logic [CountBits-1:0]    total_q, total_d;
  logic [31:0]             min_interval_q;

  // Latched input transaction.
  logic                    is_end_q, nested_q, rvalid_q, pvalid_q;
  logic [RW-1:0]           rid_q, pid_q;
  logic [TW-1:0]           now_q;

  // Values carried into the parent update.
  logic [TW-1:0]           dur_q;
  logic [EW-1:0]           fwd_q;
  logic                    same_q;

  // Memories and their ports.
  logic [EW-1:0]           tbl_mem [REGION_COUNT];
  logic [TW-1:0]           stk_mem [STACK_DEPTH];
  logic                    tbl_we, tbl_re, stk_we;
  logic [RW-1:0]           tbl_waddr, tbl_raddr;
  logic [EW-1:0]           tbl_wdata, tbl_rd_q;
  logic [SW-1:0]           stk_waddr, stk_raddr;
  logic [TW-1:0]           stk_rd_q;

  // Input decode.
  logic                    accept;
  logic [16:0]             rid_ext, pid_ext;
  logic [63:0]             ts_ext;
  logic                    in_rvalid, in_pvalid;

  // Evaluation helpers.
  logic [TW-1:0]           dur;
  logic [TW-1:0]           rd_incl, rd_child, rd_half;
  logic                    rd_valid, exceeds;
  logic [SkipBits-1:0]     skip_dec;
  logic                    go;
  logic [EW-1:0]           pent;
  logic [TW:0]             psum;
  logic [TW-1:0]           pchild;

  // Result path.
  rtm_result_t             res, out_data;
  logic                    res_load, buf_full;

  // Input side: only an idle sequencer with a free holding slot takes a
  // transaction.
  assign in_stall_o = (state_q != ST_IDLE) || buf_full;
  assign accept     = in_valid_i && !in_stall_o;
  assign rid_ext    = {7'b0, region_id_i};
  assign pid_ext    = {7'b0, parent_id_i};
  assign ts_ext     = {16'b0, timestamp_i};
  assign in_rvalid  = region_valid_i && (rid_ext < 17'(REGION_COUNT));
  assign in_pvalid  = parent_valid_i && (pid_ext < 17'(REGION_COUNT));

  // Fields of the table entry read for the region.
  assign rd_valid = tbl_rd_q[EW-1];
  assign rd_incl  = tbl_rd_q[2*TW-1:TW];
  assign rd_child = tbl_rd_q[TW-1:0];
  assign rd_half  = rd_incl >> 1;
  assign exceeds  = (rd_half > rd_child) || ((rd_half == rd_child) && rd_incl[0]);
  assign dur      = now_q - stk_rd_q;
  assign skip_dec = (skip_q != '0) ? skip_q - 1'b1 : '0;

  // Parent entry, forwarded when the parent is the region just written.
  assign pent   = same_q ? fwd_q : tbl_rd_q;
  assign psum   = {1'b0, pent[TW-1:0]} + {1'b0, dur_q};
  assign pchild = psum[TW] ? {TW{1'b1}} : psum[TW-1:0];

  // Sequencer: next state, memory accesses and the result.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    level_d     = level_q;
    measuring_d = measuring_q;
    skip_d      = skip_q;
    total_d     = total_q;
    tbl_we      = 1'b0;
    tbl_re      = 1'b0;
    tbl_waddr   = rid_q;
    tbl_raddr   = rid_ext[RW-1:0];
    tbl_wdata   = {1'b1, dur, rd_valid ? rd_child : {TW{1'b0}}};
    stk_we      = 1'b0;
    stk_waddr   = level_q[SW-1:0];
    stk_raddr   = SW'(level_q - 1'b1);
    res_load    = 1'b0;
    go          = 1'b1;
    res         = '0;
    res.action      = ACT_NONE;
    res.stack_error = ERR_OK;

    case (state_q)
      ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_q;
        tbl_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == RW'(REGION_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          tbl_re  = 1'b1;
          state_d = ST_EVAL;
        end
      end

      ST_EVAL: begin
        res_load = 1'b1;
        state_d  = ST_IDLE;
        if (nested_q) begin
          if (!is_end_q) begin
            // Begin event: count it while measuring, else push and decide.
            if (measuring_q) begin
              if (skip_q != {SkipBits{1'b1}}) begin
                skip_d = skip_q + 1'b1;
              end
            end else if (rvalid_q) begin
              if (level_q < LW'(STACK_DEPTH)) begin
                stk_we  = 1'b1;
                level_d = level_q + 1'b1;
              end else begin
                res.stack_error = ERR_OVERFLOW;
              end
              if (rd_valid && exceeds) begin
                measuring_d = 1'b1;
                skip_d      = SkipBits'(1);
                res.action  = ACT_START;
              end
            end
          end else begin
            // End event: the matching end closes the measurement.
            if (measuring_q) begin
              skip_d = skip_dec;
              if (skip_dec != '0) begin
                go = 1'b0;
              end else begin
                measuring_d = 1'b0;
                res.action  = ACT_END;
                if (total_q != {CountBits{1'b1}}) begin
                  total_d = total_q + 1'b1;
                end
              end
            end
            if (go && rvalid_q) begin
              if (level_q == '0) begin
                res.stack_error = ERR_UNDERFLOW;
              end else begin
                level_d = level_q - 1'b1;
                if (CW'(dur) > CW'(min_interval_q)) begin
                  tbl_we = 1'b1;
                  if (pvalid_q) begin
                    tbl_re    = 1'b1;
                    tbl_raddr = pid_q;
                    state_d   = ST_PARENT;
                  end
                end
              end
            end
          end
        end
        res.measured_count = total_d;
      end

      ST_PARENT: begin
        // Second access: add the duration to the parent's child time.
        tbl_we    = 1'b1;
        tbl_waddr = pid_q;
        tbl_wdata = pent[EW-1] ? {1'b1, pent[2*TW-1:TW], pchild}
                               : {1'b1, {TW{1'b0}}, dur_q};
        state_d   = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      level_q        <= '0;
      measuring_q    <= 1'b0;
      skip_q         <= '0;
      total_q        <= '0;
      min_interval_q <= MIN_INTERVAL_RESET;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      level_q     <= level_d;
      measuring_q <= measuring_d;
      skip_q      <= skip_d;
      total_q     <= total_d;
      if (cfg_wen_i) begin
        min_interval_q <= cfg_wdata_i;
      end
    end
  end

  // Latch the accepted transaction and the values for the parent update.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_end_q <= req_type_i;
      nested_q <= nested_i;
      rvalid_q <= in_rvalid;
      pvalid_q <= in_pvalid;
      rid_q    <= rid_ext[RW-1:0];
      pid_q    <= pid_ext[RW-1:0];
      now_q    <= ts_ext[TW-1:0];
    end
    if (state_q == ST_EVAL) begin
      dur_q  <= dur;
      fwd_q  <= tbl_wdata;
      same_q <= (pid_q == rid_q);
    end
  end

  // Region table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (tbl_re) begin
      tbl_rd_q <= tbl_mem[tbl_raddr];
    end
  end

  // Time stack: push in evaluation, top read when a transaction is taken.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= now_q;
    end
    if (accept) begin
      stk_rd_q <= stk_mem[stk_raddr];
    end
  end

  // Output stage.
  rtm_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .data_i      (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (out_data)
  );

  assign action_o         = out_data.action;
  assign measured_count_o = out_data.measured_count;
  assign stack_error_o    = out_data.stack_error;

`ifndef ASSERT_OFF
  // An accepted transaction is always evaluated in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EVAL)
    else $error("accepted transaction not evaluated");

  // The parent update only follows an evaluation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PARENT |-> $past(state_q) == ST_EVAL)
    else $error("parent update without evaluation");

  // Outside a measurement no nesting is counted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !measuring_q |-> skip_q == '0)
    else $error("skip depth set while not measuring");

  // The stack level only moves in evaluation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q != $past(level_q) |-> $past(state_q) == ST_EVAL)
    else $error("stack level changed outside evaluation");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for region_time_monitor: a timing-table scoreboard class
// plus stimulus and handshake processes. Depends on rtm_pkg and the monitor RTL.

// Predicts the result of every accepted event and matches it against the block output.
class region_timing_scoreboard;
  localparam int unsigned REGIONS = 1024;
  localparam int unsigned STACK_SLOTS = 64;

  logic [47:0] begin_times [STACK_SLOTS];
  int unsigned depth_used;
  bit          known [REGIONS];
  logic [47:0] incl_ticks [REGIONS];
  logic [47:0] child_ticks [REGIONS];
  bit          measuring;
  logic [15:0] skip_depth;
  logic [31:0] measure_total;
  logic [31:0] min_interval;

  rtm_pkg::rtm_result_t awaited_results [$];
  int unsigned mismatches;

  function new();
    depth_used = 0;
    measuring = 1'b0;
    skip_depth = '0;
    measure_total = '0;
    min_interval = rtm_pkg::MIN_INTERVAL_RESET;
    mismatches = 0;
    foreach (known[i]) known[i] = 1'b0;
  endfunction

  function int pending();
    return awaited_results.size();
  endfunction

  // Update the region timing state for one accepted event and queue its result.
  function void predict_event(logic is_end, logic nested, logic rvalid, logic [9:0] rid,
                              logic pvalid, logic [9:0] pid, logic [47:0] ts);
    rtm_pkg::rtm_result_t res;
    logic        proceed;
    logic [47:0] span;
    logic [48:0] sum;
    res.action = rtm_pkg::ACT_NONE;
    res.stack_error = rtm_pkg::ERR_OK;
    if (nested && !is_end) begin
      if (measuring) begin
        if (skip_depth != 16'hFFFF) skip_depth++;
      end else if (rvalid) begin
        if (depth_used < STACK_SLOTS) begin
          begin_times[depth_used] = ts;
          depth_used++;
        end else begin
          res.stack_error = rtm_pkg::ERR_OVERFLOW;
        end
        // A region qualifies when its inclusive time is more than twice its child time.
        if (known[rid] && ({1'b0, incl_ticks[rid]} > {child_ticks[rid], 1'b0})) begin
          measuring = 1'b1;
          skip_depth = 16'd1;
          res.action = rtm_pkg::ACT_START;
        end
      end
    end else if (nested) begin
      proceed = 1'b1;
      if (measuring) begin
        if (skip_depth != 0) skip_depth--;
        if (skip_depth != 0) begin
          proceed = 1'b0;
        end else begin
          measuring = 1'b0;
          if (measure_total != 32'hFFFF_FFFF) measure_total++;
          res.action = rtm_pkg::ACT_END;
        end
      end
      if (proceed && rvalid) begin
        if (depth_used == 0) begin
          res.stack_error = rtm_pkg::ERR_UNDERFLOW;
        end else begin
          depth_used--;
          span = ts - begin_times[depth_used];
          if (span > {16'd0, min_interval}) begin
            incl_ticks[rid] = span;
            if (!known[rid]) begin
              child_ticks[rid] = '0;
              known[rid] = 1'b1;
            end
            // The parent is charged after the region itself, so a self parent sees the update.
            if (pvalid) begin
              if (known[pid]) begin
                sum = {1'b0, child_ticks[pid]} + {1'b0, span};
                child_ticks[pid] = sum[48] ? '1 : sum[47:0];
              end else begin
                incl_ticks[pid] = '0;
                child_ticks[pid] = span;
                known[pid] = 1'b1;
              end
            end
          end
        end
      end
    end
    res.measured_count = measure_total;
    awaited_results.insert(awaited_results.size(), res);
  endfunction

  function void report_field(string field, longint unsigned exp, longint unsigned got);
    if (exp != got) begin
      if (mismatches < 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp, got);
      mismatches++;
    end
  endfunction

  // Compare one output transaction with the oldest prediction.
  function void check_result(rtm_pkg::rtm_result_t got);
    rtm_pkg::rtm_result_t exp;
    if (awaited_results.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: result with nothing expected, action %0d count %0d error %0d",
                 $time, got.action, got.measured_count, got.stack_error);
      mismatches++;
    end else begin
      exp = awaited_results.pop_front();
      report_field("action", exp.action, got.action);
      report_field("measured_count", exp.measured_count, got.measured_count);
      report_field("stack_error", exp.stack_error, got.stack_error);
    end
  endfunction
endclass

module testbench;
  import rtm_pkg::*;

  localparam int unsigned CLK_PERIOD = 20;
  localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
  localparam int unsigned PHASE_EVENTS = 240;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic REQ_BEGIN = 1'b0;
  localparam logic REQ_END = 1'b1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_wen_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        req_type_i = 1'b0;
  logic        nested_i = 1'b0;
  logic        region_valid_i = 1'b0;
  logic [9:0]  region_id_i = '0;
  logic        parent_valid_i = 1'b0;
  logic [9:0]  parent_id_i = '0;
  logic [47:0] timestamp_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  action_o;
  logic [31:0] measured_count_o;
  logic [1:0]  stack_error_o;

  region_timing_scoreboard sb;
  int unsigned burst_left;
  int unsigned event_count;
  bit          hold_off_req;
  logic [47:0] now_ticks;

  region_time_monitor DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_wen_i        (cfg_wen_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .nested_i         (nested_i),
    .region_valid_i   (region_valid_i),
    .region_id_i      (region_id_i),
    .parent_valid_i   (parent_valid_i),
    .parent_id_i      (parent_id_i),
    .timestamp_i      (timestamp_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .action_o         (action_o),
    .measured_count_o (measured_count_o),
    .stack_error_o    (stack_error_o)
  );

  // Free-running clock.
  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Hard limit on the run length.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("region_time_monitor verification failed");
    $finish;
  end

  // Output monitor: every accepted result transaction goes to the scoreboard.
  initial begin
    rtm_result_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.action = action_o;
        got.measured_count = measured_count_o;
        got.stack_error = stack_error_o;
        sb.check_result(got);
      end
    end
  end

  // Receiver stall pattern; a requested hold-off stalls for a long counted stretch.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 9) < 3);
          2: out_stall_i <= ($urandom_range(0, 9) < 7);
          default: out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  // Offer one event transaction and hold it until accepted; bursts are mostly separated by gaps.
  task automatic send_event(input logic is_end, input logic nested, input logic rvalid,
                            input logic [9:0] rid, input logic pvalid,
                            input logic [9:0] pid, input logic [47:0] ts);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    req_type_i <= is_end;
    nested_i <= nested;
    region_valid_i <= rvalid;
    region_id_i <= rid;
    parent_valid_i <= pvalid;
    parent_id_i <= pid;
    timestamp_i <= ts;
    do @(posedge clk_i); while (in_stall_o);
    sb.predict_event(is_end, nested, rvalid, rid, pvalid, pid, ts);
    burst_left--;
    if (nested) event_count++;
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_min_interval(input logic [31:0] value);
    cfg_wen_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.min_interval = value;
    cfg_wen_i <= 1'b0;
    cfg_wdata_i <= $urandom;
  endtask

  // Time moves in steps around the minimum interval, with an occasional huge jump.
  task automatic advance_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 19) == 0) now_ticks += r[47:0];
    else now_ticks += 48'(r % ({32'd0, sb.min_interval} * 2 + 64));
  endtask

  // Mostly a small set of regions so entries are revisited, plus bit-pattern extremes.
  function automatic logic [9:0] pick_region();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) return 10'($urandom_range(0, 15));
    if (sel < 17) begin
      case ($urandom_range(0, 3))
        0: return 10'd0;
        1: return 10'h3FF;
        2: return 10'h2AA;
        default: return 10'h155;
      endcase
    end
    return 10'($urandom_range(0, 1023));
  endfunction

  // A well-formed begin/end nest with random content and the odd broken link.
  task automatic send_tree(input int unsigned depth, input logic pvalid,
                           input logic [9:0] pid);
    logic [9:0]  rid;
    logic [9:0]  end_pid;
    logic        end_pvalid;
    int unsigned kids;
    rid = pick_region();
    advance_time();
    send_event(REQ_BEGIN, 1'b1, 1'b1, rid, 1'b0, 10'($urandom_range(0, 1023)), now_ticks);
    kids = (depth < 5) ? $urandom_range(0, 2) : 0;
    repeat (kids) send_tree(depth + 1, 1'b1, rid);
    if ($urandom_range(0, 29) == 0) begin
      advance_time();
      send_event(REQ_END, 1'b1, 1'b1, pick_region(), 1'b1, pick_region(), now_ticks);
    end
    // A dropped end leaves a dangling begin time on the stack.
    if ($urandom_range(0, 19) != 0) begin
      end_pvalid = pvalid;
      end_pid = pid;
      case ($urandom_range(0, 19))
        0, 1: end_pvalid = 1'b0;
        2, 3: end_pid = 10'($urandom_range(0, 1023));
        4: end_pid = rid;
        default: ;
      endcase
      advance_time();
      send_event(REQ_END, 1'b1, 1'b1, rid, end_pvalid, end_pid, now_ticks);
    end
  endtask

  task automatic send_noise();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) begin
      send_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                 1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)), r[47:0]);
    end else begin
      advance_time();
      send_event(1'($urandom_range(0, 1)), 1'b1, 1'b1, pick_region(), 1'b1,
                 pick_region(), now_ticks);
    end
  endtask

  // End events until the stack is empty and no measurement is open.
  task automatic drain_stack();
    while (sb.depth_used != 0 || sb.measuring) begin
      advance_time();
      send_event(REQ_END, 1'b1, 1'b1, pick_region(), 1'($urandom_range(0, 1)),
                 pick_region(), now_ticks);
    end
  endtask

  // Push past the stack depth with regions that cannot start a measurement.
  task automatic flood_stack();
    logic [9:0] rid;
    drain_stack();
    repeat (70) begin
      do rid = 10'($urandom_range(0, 1023)); while (sb.known[rid]);
      advance_time();
      send_event(REQ_BEGIN, 1'b1, 1'b1, rid, 1'b0, 10'd0, now_ticks);
    end
    drain_stack();
  endtask

  // Main sequence: reset, directed corner cases, then randomized phases.
  initial begin
    logic [31:0] setting;
    int unsigned phase_start;
    sb = new();
    burst_left = 0;
    event_count = 0;
    hold_off_req = 1'b0;
    now_ticks = 48'({$urandom, $urandom});
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Ignored event, missing region, underflow with a region, and an end without a region.
    send_event(REQ_BEGIN, 1'b0, 1'b1, 10'd3, 1'b0, 10'd0, 48'd5);
    send_event(REQ_BEGIN, 1'b1, 1'b0, 10'd3, 1'b0, 10'd0, 48'd6);
    send_event(REQ_END, 1'b1, 1'b1, 10'd3, 1'b0, 10'd0, 48'd7);
    send_event(REQ_END, 1'b1, 1'b0, 10'd3, 1'b0, 10'd0, 48'd8);
    // Timestamp wrap records region 0 and creates an unknown parent.
    send_event(REQ_BEGIN, 1'b1, 1'b1, 10'd0, 1'b0, 10'd0, 48'hFFFF_FFFF_FFF6);
    send_event(REQ_END, 1'b1, 1'b1, 10'd0, 1'b1, 10'h3FF, 48'd2_000_000);
    // Measurement start, skipped nesting, and closing end handled as a normal end.
    send_event(REQ_BEGIN, 1'b1, 1'b1, 10'd0, 1'b0, 10'd0, 48'd3_000_000);
    send_event(REQ_BEGIN, 1'b1, 1'b1, 10'd3, 1'b0, 10'd0, 48'd3_000_100);
    send_event(REQ_END, 1'b1, 1'b1, 10'd3, 1'b0, 10'd0, 48'd3_000_200);
    send_event(REQ_END, 1'b1, 1'b1, 10'd0, 1'b0, 10'd0, 48'd3_000_300);
    // Parent-only entry does not qualify.
    send_event(REQ_BEGIN, 1'b1, 1'b1, 10'h3FF, 1'b0, 10'd0, 48'd4_000_000);
    send_event(REQ_END, 1'b1, 1'b1, 10'h3FF, 1'b0, 10'd0, 48'd4_000_001);
    // Region is its own parent; the second pass saturates the child time.
    send_event(REQ_BEGIN, 1'b1, 1'b1, 10'd5, 1'b0, 10'd0, 48'd0);
    send_event(REQ_END, 1'b1, 1'b1, 10'd5, 1'b1, 10'd5, 48'hFFFF_FFFF_FFFF);
    send_event(REQ_BEGIN, 1'b1, 1'b1, 10'd5, 1'b0, 10'd0, 48'd0);
    send_event(REQ_END, 1'b1, 1'b1, 10'd5, 1'b1, 10'd5, 48'hFFFF_FFFF_FFFF);
    // Inclusive time exactly twice the child time must not start a measurement.
    send_event(REQ_BEGIN, 1'b1, 1'b1, 10'd7, 1'b0, 10'd0, 48'd10_000_000);
    send_event(REQ_BEGIN, 1'b1, 1'b1, 10'd8, 1'b0, 10'd0, 48'd10_000_000);
    send_event(REQ_END, 1'b1, 1'b1, 10'd8, 1'b1, 10'd7, 48'd13_000_000);
    send_event(REQ_END, 1'b1, 1'b1, 10'd7, 1'b0, 10'd0, 48'd16_000_000);
    send_event(REQ_BEGIN, 1'b1, 1'b1, 10'd7, 1'b0, 10'd0, 48'd20_000_000);
    // Duration equal to the minimum interval is not recorded.
    send_event(REQ_END, 1'b1, 1'b1, 10'd7, 1'b0, 10'd0, 48'd21_000_000);

    // Random phases, each under its own minimum interval.
    for (int unsigned phase = 0; phase < 5; phase++) begin
      wait_drained();
      case (phase)
        0: setting = 32'd0;
        1: setting = 32'hFFFF_FFFF;
        2: setting = MIN_INTERVAL_RESET;
        3: setting = $urandom_range(1, 5000);
        default: setting = $urandom;
      endcase
      write_min_interval(setting);
      hold_off_req = 1'b1;
      if (phase == 1 || phase == 3) flood_stack();
      phase_start = event_count;
      while (event_count - phase_start < PHASE_EVENTS) begin
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) send_noise();
        else send_tree(0, 1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("region_time_monitor verification clean");
    end else begin
      $display("region_time_monitor verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/rtm_pkg.sv
design/rtm_out_buf.sv
design/region_time_monitor.sv
test/testbench.sv
